// ===== rtl/core/bitmap_block_allocator_unit_assert.svh =====
// bitmap_block_allocator_unit_assert.svh: assertion macros for the block allocator
// expects i_clk and i_rst_n in the including module, no other dependencies
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
// bba_pkg.sv: shared types and constants of the bitmap block allocator
// no dependencies; imported by bba_ctrl, bba_dpath and the top level
package bba_pkg;

    // sizing
    localparam int MAX_BLOCKS  = 32768;
    localparam int BLOCK_BYTES = 4096;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = MAX_BLOCKS / WORD_BITS;
    localparam int MAP_AW      = $clog2(MAP_WORDS);
    localparam int IDX_W       = MAP_AW + 1;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int BLK_W       = $clog2(MAX_BLOCKS);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int ADDR_W      = 32;
    localparam int REQ_BLK_W   = ADDR_W - BLOCK_SHIFT;
    localparam int CNT_W       = 16;
    localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(MAX_BLOCKS);

    // command codes
    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_FREE    = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_RESERVE = 3'd3;
    localparam logic [2:0] CMD_REINIT  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // input and result beats
    typedef struct packed {
        logic [2:0]        cmd;
        logic [ADDR_W-1:0] byte_address;
        logic [ADDR_W-1:0] region_bytes;
    } t_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] alloc_address;
        logic [CNT_W-1:0]  free_count;
    } t_result;

    // controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_BLK_CHK,
        S_BLK_WR,
        S_ZERO_RD,
        S_ZERO_WR,
        S_REINIT,
        S_FINISH
    } t_state;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SWEEP,
        DP_SCAN_RD,
        DP_SCAN_CHK,
        DP_BLK_RD,
        DP_BLK_WR,
        DP_ZERO_RD,
        DP_ZERO_WR,
        DP_RANGE_ERR,
        DP_NOFREE,
        DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic       blk_in_range;
        logic       left_zero;
        logic       scan_done;
        logic       word_full;
        logic       sweep_last;
    } t_dp_status;

endpackage

// ===== rtl/core/bba_ctrl.sv =====
// bba_ctrl.sv: sequencer of the bitmap block allocator
// depends on bba_pkg and bitmap_block_allocator_unit_assert.svh
`include "bitmap_block_allocator_unit_assert.svh"

module bba_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [2:0]          i_item_cmd,
    input  bba_pkg::t_dp_status i_status,
    output logic                busy,
    output bba_pkg::t_dp_cmd    o_cmd
);
    import bba_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    unique case (i_item_cmd)
                        CMD_ALLOC:   n_state = S_ALLOC_RD;
                        CMD_FREE:    n_state = S_BLK_CHK;
                        CMD_RELEASE: n_state = S_BLK_CHK;
                        CMD_RESERVE: n_state = S_BLK_CHK;
                        CMD_REINIT:  n_state = S_REINIT;
                        default:     n_state = S_FINISH;
                    endcase
                end
            end
            S_ALLOC_RD: begin
                n_state = i_status.scan_done ? S_FINISH : S_ALLOC_CHK;
            end
            S_ALLOC_CHK: begin
                n_state = i_status.word_full ? S_ALLOC_RD : S_FINISH;
            end
            S_BLK_CHK: begin
                if (i_status.left_zero || !i_status.blk_in_range) begin
                    n_state = (i_status.cmd == CMD_RELEASE) ? S_ZERO_RD : S_FINISH;
                end else begin
                    n_state = S_BLK_WR;
                end
            end
            S_BLK_WR:  n_state = S_BLK_CHK;
            S_ZERO_RD: n_state = S_ZERO_WR;
            S_ZERO_WR: n_state = S_FINISH;
            S_REINIT: begin
                if (i_status.sweep_last) n_state = S_FINISH;
            end
            S_FINISH:  n_state = S_IDLE;
            default:   n_state = S_INIT;
        endcase
    end

    // datapath command and busy
    always_comb begin
        busy     = 1'b1;
        o_cmd.op = DP_NOP;
        unique case (r_state)
            S_INIT:      o_cmd.op = DP_SWEEP;
            S_IDLE: begin
                busy = 1'b0;
                if (start) o_cmd.op = DP_LOAD;
            end
            S_ALLOC_RD:  o_cmd.op = i_status.scan_done ? DP_NOFREE : DP_SCAN_RD;
            S_ALLOC_CHK: o_cmd.op = DP_SCAN_CHK;
            S_BLK_CHK: begin
                if (i_status.left_zero) begin
                    o_cmd.op = DP_NOP;
                end else if (!i_status.blk_in_range) begin
                    o_cmd.op = DP_RANGE_ERR;
                end else begin
                    o_cmd.op = DP_BLK_RD;
                end
            end
            S_BLK_WR:    o_cmd.op = DP_BLK_WR;
            S_ZERO_RD:   o_cmd.op = DP_ZERO_RD;
            S_ZERO_WR:   o_cmd.op = DP_ZERO_WR;
            S_REINIT:    o_cmd.op = DP_SWEEP;
            S_FINISH:    o_cmd.op = DP_FINISH;
            default:     o_cmd.op = DP_NOP;
        endcase
    end

    // read-modify-write steps always follow their read
    `BBA_ASSERT_IMP(a_scan_after_rd, r_state == S_ALLOC_CHK, $past(r_state == S_ALLOC_RD), "scan check without read")
    `BBA_ASSERT_IMP(a_blk_after_rd, r_state == S_BLK_WR, $past(r_state == S_BLK_CHK), "block write without read")
    `BBA_ASSERT_IMP(a_zero_after_rd, r_state == S_ZERO_WR, $past(r_state == S_ZERO_RD), "block 0 write without read")

endmodule

// ===== rtl/core/bba_dpath.sv =====
// bba_dpath.sv: used map memory, free counter, block walker and result register
// depends on bba_pkg and bitmap_block_allocator_unit_assert.svh
`include "bitmap_block_allocator_unit_assert.svh"

module bba_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bba_pkg::t_dp_cmd              i_cmd,
    input  bba_pkg::t_item                i_item,
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0]     i_cfg_wdata,
    output bba_pkg::t_dp_status           o_status,
    output bba_pkg::t_result              o_result,
    output logic                          o_result_strobe
);
    import bba_pkg::*;

    // lowest clear bit of a map word
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) pos = BIT_W'(i);
        end
        return pos;
    endfunction

    logic [WORD_BITS-1:0] r_map [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_free;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_strobe;
    logic [2:0]           r_cmd;
    logic [REQ_BLK_W-1:0] r_blk;
    logic [REQ_BLK_W-1:0] r_left;
    logic [1:0]           r_status;
    logic [ADDR_W-1:0]    r_alloc;
    t_result              r_result;

    logic [CNT_W-1:0]     eff_total;
    logic [IDX_W-1:0]     scan_words;
    logic [BIT_W-1:0]     zero_pos;
    logic [WORD_BITS-1:0] alloc_mask;
    logic [WORD_BITS-1:0] blk_mask;
    logic                 word_full;
    logic                 set_mode;
    logic [MAP_AW-1:0]    blk_word;
    logic [CNT_W-1:0]     cnt_up;
    logic [CNT_W-1:0]     cnt_down;

    logic                 mem_re;
    logic [MAP_AW-1:0]    mem_raddr;
    logic                 mem_we;
    logic [MAP_AW-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // effective total, scan limit and bit helpers
    always_comb begin
        eff_total  = (r_total > TOTAL_RESET) ? TOTAL_RESET : r_total;
        scan_words = IDX_W'(eff_total >> BIT_W);
        word_full  = (r_rdata == '1);
        zero_pos   = lowest_zero(r_rdata);
        alloc_mask = WORD_BITS'(1) << zero_pos;
        blk_mask   = WORD_BITS'(1) << r_blk[BIT_W-1:0];
        blk_word   = r_blk[BLK_W-1:BIT_W];
        set_mode   = (r_cmd == CMD_RESERVE);
        cnt_up     = (r_free < eff_total) ? r_free + CNT_W'(1) : r_free;
        cnt_down   = (r_free != '0) ? r_free - CNT_W'(1) : r_free;
    end

    // status toward the sequencer
    always_comb begin
        o_status.cmd          = r_cmd;
        o_status.blk_in_range = (r_blk < REQ_BLK_W'(eff_total));
        o_status.left_zero    = (r_left == '0);
        o_status.scan_done    = (r_idx >= scan_words);
        o_status.word_full    = word_full;
        o_status.sweep_last   = (r_idx[MAP_AW-1:0] == MAP_AW'(MAP_WORDS - 1));
    end

    // memory port steering
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '1;
        unique case (i_cmd.op)
            DP_SCAN_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx[MAP_AW-1:0];
            end
            DP_BLK_RD: begin
                mem_re    = 1'b1;
                mem_raddr = blk_word;
            end
            DP_ZERO_RD: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            DP_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[MAP_AW-1:0];
                mem_wdata = '1;
            end
            DP_SCAN_CHK: begin
                mem_we    = !word_full;
                mem_waddr = r_idx[MAP_AW-1:0];
                mem_wdata = r_rdata | alloc_mask;
            end
            DP_BLK_WR: begin
                mem_we    = 1'b1;
                mem_waddr = blk_word;
                mem_wdata = set_mode ? (r_rdata | blk_mask) : (r_rdata & ~blk_mask);
            end
            DP_ZERO_WR: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_rdata | WORD_BITS'(1);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // used map memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_map[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_map[mem_raddr];
    end

    // control registers: total, free count, word index, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= TOTAL_RESET;
            r_free   <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == DP_FINISH);
            if (i_cfg_we) r_total <= i_cfg_wdata;
            unique case (i_cmd.op)
                DP_LOAD: begin
                    r_idx <= '0;
                end
                DP_SWEEP: begin
                    r_idx  <= r_idx + IDX_W'(1);
                    r_free <= '0;
                end
                DP_SCAN_CHK: begin
                    if (word_full) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end else begin
                        r_free <= cnt_down;
                    end
                end
                DP_BLK_WR: begin
                    r_free <= set_mode ? cnt_down : cnt_up;
                end
                default: begin
                    r_free <= r_free;
                end
            endcase
        end
    end

    // payload registers: request, walker, result beat
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_cmd    <= i_item.cmd;
                r_blk    <= i_item.byte_address[ADDR_W-1:BLOCK_SHIFT];
                r_left   <= (i_item.cmd == CMD_FREE) ? REQ_BLK_W'(1)
                                                     : i_item.region_bytes[ADDR_W-1:BLOCK_SHIFT];
                r_status <= ST_OK;
                r_alloc  <= '0;
            end
            DP_SCAN_CHK: begin
                if (!word_full) begin
                    r_alloc <= ADDR_W'({r_idx[MAP_AW-1:0], zero_pos}) << BLOCK_SHIFT;
                end
            end
            DP_BLK_WR: begin
                r_blk  <= r_blk + REQ_BLK_W'(1);
                r_left <= r_left - REQ_BLK_W'(1);
            end
            DP_RANGE_ERR: r_status <= ST_RANGE;
            DP_NOFREE:    r_status <= ST_NOFREE;
            DP_FINISH: begin
                r_result.status        <= r_status;
                r_result.alloc_address <= r_alloc;
                r_result.free_count    <= r_free;
            end
            default: begin
                r_blk <= r_blk;
            end
        endcase
    end

    assign o_result        = r_result;
    assign o_result_strobe = r_strobe;

    // free count moves by at most one block per cycle, or drops to zero
    `BBA_ASSERT_IMP(a_free_step, 1'b1, (r_free == $past(r_free)) || (r_free == $past(r_free) + CNT_W'(1)) || (r_free == $past(r_free) - CNT_W'(1)) || (r_free == '0), "free count jumped")
    // only a successful allocate reports an address
    `BBA_ASSERT_IMP(a_addr_ok_only, r_strobe && (r_result.status != ST_OK), r_result.alloc_address == '0, "address on failed command")
    // a result beat lasts one cycle
    `BBA_ASSERT_NXT(a_strobe_pulse, r_strobe, !r_strobe, "result strobe held")

endmodule

// ===== rtl/core/bitmap_block_allocator_unit.sv =====
// bitmap_block_allocator_unit.sv: top level of the bitmap block allocator
// depends on bba_pkg, bba_ctrl and bba_dpath
// Time from accept to result strobe depends on the command: reinitialize sweeps
// the whole map, free and region commands walk their blocks in turn, release then
// also marks block 0 used, and allocate scans map words in order until one holds a
// clear bit. All map traffic goes through the used-map memory, one read or write per
// cycle, one item at a time. Synchronous reset sweeps the map to all-used with busy
// high; configuration writes are taken during that sweep. Results cannot be stalled.
module bitmap_block_allocator_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bba_pkg::t_item            i_item,
    input  logic                      i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0] i_cfg_wdata,
    output bba_pkg::t_result          o_result,
    output logic                      o_result_strobe
);
    import bba_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item_cmd (i_item.cmd),
        .i_status   (dp_status),
        .busy       (busy),
        .o_cmd      (dp_cmd)
    );

    // map, counters and result beat
    bba_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_item          (i_item),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_status        (dp_status),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

endmodule
